// File: design/csvs_pkg.sv
// shared constants and types for the csv cell and row splitter
package csvs_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ChDquote = 8'h22;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] SepReset = 8'd44;

  localparam logic [3*ByteW-1:0] SmartOpen  = 24'hE2809C;
  localparam logic [3*ByteW-1:0] SmartClose = 24'hE2809D;

  // one classified byte on its way to the output
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_content;
    logic             cell_end;
    logic             row_end;
  } res_t;

endpackage

// File: design/csvs_classify.sv
// per-byte quote tracking and cell and row end detection
module csvs_classify (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [csvs_pkg::ByteW-1:0] in_byte_i,
  input  logic [csvs_pkg::ByteW-1:0] separator_i,
  output csvs_pkg::res_t            res_o
);
  import csvs_pkg::*;

  logic                plain_q, plain_d;
  logic                smart_q, smart_d;
  logic [2*ByteW-1:0]  hist_q;
  logic                line_start_q;
  logic [3*ByteW-1:0]  seq;
  logic [ByteW-1:0]    prev;
  logic                term, ends_row, ends_cell;

  always_comb begin
    seq     = {hist_q, in_byte_i};
    prev    = hist_q[ByteW-1:0];
    smart_d = smart_q;
    if (seq == SmartOpen)  smart_d = 1'b1;
    if (seq == SmartClose) smart_d = 1'b0;
    plain_d = (in_byte_i == ChDquote) ? !plain_q : plain_q;
    term = ((in_byte_i == separator_i) || (in_byte_i == ChCr) || (in_byte_i == ChLf))
           && !plain_d && !smart_d;
    ends_row  = term && (in_byte_i == ChLf);
    ends_cell = term && !line_start_q && (prev != ChCr) && (prev != ChLf);
    res_o.out_byte   = in_byte_i;
    res_o.is_content = !term;
    res_o.cell_end   = ends_cell;
    res_o.row_end    = ends_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_q      <= 1'b0;
      smart_q      <= 1'b0;
      hist_q       <= '0;
      line_start_q <= 1'b1;
    end else if (accept_i) begin
      plain_q      <= plain_d;
      smart_q      <= smart_d;
      hist_q       <= {hist_q[ByteW-1:0], in_byte_i};
      line_start_q <= ends_row;
    end
  end

endmodule

// File: design/csvs_skid.sv
// output register with one skid entry
module csvs_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  csvs_pkg::res_t in_res_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output csvs_pkg::res_t out_res_o
);
  import csvs_pkg::*;

  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;
  logic in_acc, out_free;

  assign in_ready_o  = !skid_v_q;
  assign in_acc      = in_valid_i && !skid_v_q;
  assign out_free    = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || in_acc;
      skid_v_q <= 1'b0;
    end else if (in_acc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) out_q <= skid_q;
      else if (in_acc) out_q <= in_res_i;
    end else if (in_acc) begin
      skid_q <= in_res_i;
    end
  end

endmodule

// File: design/csv_field_splitter.sv
// top level of the streaming csv cell and row splitter
//
// usage
// - input channel: in_valid_i with in_byte_i, one text byte per word; the
//   block holds in_stall_o high when it cannot take a word
// - output channel: out_valid_o with out_byte_o, is_content_o, cell_end_o and
//   row_end_o, exactly one result word per input word, in order; the
//   receiver holds out_stall_i high to pause it
// - separator: written through cfg_valid_i and cfg_data_i while idle;
//   cfg_ready_o is always high, resets to comma
// - result path: a byte's classification is combinational and is registered in
//   the result register, or in the skid entry while a result waits
// - throughput: one byte per cycle while in_stall_o is low, set by the
//   combinational quote and terminator logic ahead of the result register
// - stalls: a skid entry behind the result register lets one more byte in
//   while a result waits; in_stall_o rises only once both are full
// - reset: quote states closed, byte history cleared, start of line set,
//   output and skid empty
module csv_field_splitter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [csvs_pkg::ByteW-1:0] in_byte_i,
  // result stream
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [csvs_pkg::ByteW-1:0] out_byte_o,
  output logic                       is_content_o,
  output logic                       cell_end_o,
  output logic                       row_end_o,
  // separator register
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [csvs_pkg::ByteW-1:0] cfg_data_i
);
  import csvs_pkg::*;

  logic [ByteW-1:0] sep_q;
  logic             in_ready;
  logic             in_acc;
  res_t             cls_res;
  res_t             out_res;

  // config word is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SepReset;
    end else if (cfg_valid_i) begin
      sep_q <= cfg_data_i;
    end
  end

  // stall only when the skid entry is occupied
  assign in_stall_o = !in_ready;
  assign in_acc     = in_valid_i && in_ready;

  // quote state and terminator logic, state moves on each accepted word
  csvs_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .in_byte_i   (in_byte_i),
    .separator_i (sep_q),
    .res_o       (cls_res)
  );

  // result register plus skid entry
  csvs_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_res_i    (cls_res),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign out_byte_o   = out_res.out_byte;
  assign is_content_o = out_res.is_content;
  assign cell_end_o   = out_res.cell_end;
  assign row_end_o    = out_res.row_end;

endmodule

// File: tb/csv_field_splitter_tb.sv
// self-checking testbench for the streaming csv cell and row splitter
`timescale 1ns / 100ps

module csv_field_splitter_tb;
  import csvs_pkg::*;

  // bytes of the typographic quote sequences, taken apart from the package constants
  localparam logic [ByteW-1:0] Utf8Lead  = SmartOpen[23:16];
  localparam logic [ByteW-1:0] Utf8Mid   = SmartOpen[15:8];
  localparam logic [ByteW-1:0] OpenTail  = SmartOpen[7:0];
  localparam logic [ByteW-1:0] CloseTail = SmartClose[7:0];

  // directed opening: leading separator at reset, a plain cell, a quoted cell holding a
  // separator and an lf, cr lf giving one cell end, a blank line, byte extremes, a
  // typographic span holding a separator and a cr, a leading separator after a row end
  localparam logic [ByteW-1:0] OpeningText [25] = '{
    SepReset, 8'h61, SepReset, ChDquote, SepReset, ChLf, ChDquote, ChCr, ChLf, ChLf,
    8'h00, 8'hFF, Utf8Lead, Utf8Mid, OpenTail, SepReset, ChCr, Utf8Lead, Utf8Mid, CloseTail,
    SepReset, ChLf, SepReset, 8'h7A, ChCr
  };

  // separator settings, one per random phase: extremes, semicolon, tab, quote bytes, back to comma
  localparam logic [ByteW-1:0] SepPlan [8] = '{
    8'h00, 8'h3B, 8'hFF, 8'h09, ChDquote, Utf8Lead, Utf8Mid, SepReset
  };

  localparam int LongHoldCycles = 120;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] in_byte_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [ByteW-1:0] out_byte_o;
  logic             is_content_o;
  logic             cell_end_o;
  logic             row_end_o;
  logic             cfg_valid_i  = 1'b0;
  logic             cfg_ready_o;
  logic [ByteW-1:0] cfg_data_i   = SepReset;

  csv_field_splitter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_content_o (is_content_o),
    .cell_end_o   (cell_end_o),
    .row_end_o    (row_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // text waiting to be offered, and classifications still owed by the block
  logic [ByteW-1:0] text_bytes [$];
  res_t             pending_classes [$];

  int bytes_queued = 0;   // written by the stimulus only
  int bytes_taken  = 0;   // written at the rising edge only
  int sep_writes   = 0;
  int errors       = 0;

  // own copy of the splitter state, stepped once per accepted word
  logic [ByteW-1:0]   sep_model   = SepReset;
  logic               plain_open  = 1'b0;
  logic               smart_open  = 1'b0;
  logic [2*ByteW-1:0] recent      = '0;
  logic               line_start  = 1'b1;

  logic in_took     = 1'b0;  // the word on the input was accepted at the last edge
  int   gap_left    = 0;
  int   stall_left  = 0;
  int   hold_left   = 0;
  bit   hold_wanted = 1'b0;
  bit   hold_taken  = 1'b0;
  bit   quiet       = 1'b0;  // a phase with no idling on either side

  // quote states move first, then the byte is judged as a terminator against them
  function res_t classify_byte(input logic [ByteW-1:0] b);
    logic [3*ByteW-1:0] seq;
    logic               term;
    res_t               r;
    seq = {recent, b};
    if (seq == SmartOpen) smart_open = 1'b1;
    if (seq == SmartClose) smart_open = 1'b0;
    if (b == ChDquote) plain_open = ~plain_open;
    term = (b == sep_model || b == ChCr || b == ChLf) && !plain_open && !smart_open;
    r.out_byte   = b;
    r.is_content = ~term;
    // no cell end at the start of a line, nor straight after cr or lf, whatever quote state
    r.cell_end   = term && !line_start && recent[7:0] != ChCr && recent[7:0] != ChLf;
    r.row_end    = term && (b == ChLf);
    recent       = {recent[7:0], b};
    line_start   = r.row_end;
    return r;
  endfunction

  // idle lengths: mostly none, some short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------------
  // sender: offers one word at a time, holds it while stalled, idles between words
  // ---------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // word still waiting, keep it steady
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left   <= gap_left - 1;
    end else if (text_bytes.size() != 0) begin
      in_valid_i <= 1'b1;
      in_byte_i  <= text_bytes.pop_front();
      gap_left   <= pick_idle();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off counted here so that the
  // result register and skid entry fill and the block stalls its input
  // ---------------------------------------------------------------------------------
  always @(negedge clk_i) begin : rx_side
    int n;
    n = 0;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_wanted && !hold_taken) begin
      out_stall_i <= 1'b1;
      hold_left   <= LongHoldCycles - 1;
      hold_taken  <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      n = pick_idle();
      out_stall_i <= (n != 0);
      stall_left  <= (n != 0) ? n - 1 : 0;
    end
  end

  // ---------------------------------------------------------------------------------
  // monitor: at each rising edge, note separator writes, predict every accepted word
  // and compare every delivered result with the oldest prediction
  // ---------------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    res_t want;
    in_took <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        sep_model = cfg_data_i;
        sep_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        pending_classes.push_back(classify_byte(in_byte_i));
        bytes_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_classes.size() == 0) begin
          $display("%0t: result with none expected, actual byte %0h", $time, out_byte_o);
          errors++;
        end else begin
          want = pending_classes.pop_front();
          check_field("out_byte", int'(want.out_byte), int'(out_byte_o));
          check_field("is_content", int'(want.is_content), int'(is_content_o));
          check_field("cell_end", int'(want.cell_end), int'(cell_end_o));
          check_field("row_end", int'(want.row_end), int'(row_end_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------------
  task automatic put_byte(input logic [ByteW-1:0] b);
    text_bytes.push_back(b);
    bytes_queued++;
  endtask

  // cell text; inside quotes it may carry separators and line breaks
  task automatic put_content(input int len, input bit quoted);
    logic [ByteW-1:0] b;
    int               i;
    for (i = 0; i < len; i++) begin
      if (quoted && $urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0:       b = sep_model;
          1:       b = ChCr;
          default: b = ChLf;
        endcase
      end else begin
        do begin
          b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(32, 126));
        end while (b == ChDquote || b == Utf8Lead || b == sep_model || b == ChCr || b == ChLf);
      end
      put_byte(b);
    end
  endtask

  // one well-formed row with random cells and a random line ending
  task automatic put_row();
    int cells;
    int i;
    cells = $urandom_range(1, 5);
    if ($urandom_range(0, 5) == 0) put_byte(sep_model);
    for (i = 0; i < cells; i++) begin
      if (i != 0) put_byte(sep_model);
      case ($urandom_range(0, 5))
        0: ;
        1, 2: put_content($urandom_range(1, 6), 1'b0);
        3: begin
          put_byte(ChDquote);
          put_content($urandom_range(0, 6), 1'b1);
          if ($urandom_range(0, 3) == 0) begin
            // doubled quote inside a quoted cell
            put_byte(ChDquote);
            put_byte(ChDquote);
            put_content($urandom_range(0, 3), 1'b1);
          end
          put_byte(ChDquote);
        end
        4: begin
          put_byte(Utf8Lead); put_byte(Utf8Mid); put_byte(OpenTail);
          put_content($urandom_range(0, 6), 1'b1);
          put_byte(Utf8Lead); put_byte(Utf8Mid); put_byte(CloseTail);
        end
        default: put_content($urandom_range(7, 12), 1'b0);
      endcase
    end
    case ($urandom_range(0, 4))
      0, 1: put_byte(ChLf);
      2: begin put_byte(ChCr); put_byte(ChLf); end
      3: put_byte(ChCr);
      default: begin put_byte(ChLf); put_byte(ChLf); end
    endcase
  endtask

  // raw bytes and broken or unbalanced quote sequences
  task automatic put_noise();
    case ($urandom_range(0, 5))
      0: repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      1: put_byte(ChDquote);
      2: begin put_byte(Utf8Lead); put_byte(Utf8Mid); end
      3: begin put_byte(Utf8Lead); put_byte(Utf8Mid); put_byte(CloseTail); end
      4: begin put_byte(Utf8Lead); put_byte(Utf8Mid); put_byte(OpenTail); end
      default: begin put_byte(ChCr); put_byte(sep_model); put_byte(ChLf); end
    endcase
  endtask

  task automatic put_traffic(input int n_bytes);
    int stop_at;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      if ($urandom_range(0, 9) < 8) put_row();
      else put_noise();
    end
  endtask

  // every queued word taken and every result in; one result per word, so a short pause
  task automatic settle();
    do @(negedge clk_i);
    while (bytes_taken != bytes_queued || pending_classes.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_sep(input logic [ByteW-1:0] v);
    int seen;
    seen = sep_writes;
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i);
    while (sep_writes == seen);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset separator
    foreach (OpeningText[i]) put_byte(OpeningText[i]);
    settle();

    // random phases, each under its own separator; the state carries across
    foreach (SepPlan[p]) begin
      write_sep(SepPlan[p]);
      quiet = (p == 3);
      put_traffic(55);
      if (p == 1) hold_wanted = 1'b1;
      settle();
    end
    quiet = 1'b0;

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("csv_field_splitter_tb passed");
    end else begin
      $display("csv_field_splitter_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("csv_field_splitter_tb failed");
    $finish;
  end

endmodule
